### sv/dft_pkg.sv
// ============================================================================
// dft_pkg
// Shared types, constants and the quarter-wave twiddle table of the direct
// DFT bin engine.
// ============================================================================
`default_nettype none

package dft_pkg;

    localparam int DFT_POINTS  = 1024;
    localparam int ADDR_W      = $clog2(DFT_POINTS);
    localparam int SAMPLE_W    = 16;
    localparam int TW_W        = 16;
    localparam int PROD_W      = SAMPLE_W + TW_W;
    localparam int ACC_W       = 42;
    localparam int OUT_SHIFT   = ADDR_W + 15;
    localparam int SCALED_W    = ACC_W - OUT_SHIFT;
    localparam int TW_QUARTER  = DFT_POINTS / 4;
    localparam int QR_W        = ADDR_W - 2;
    localparam longint unsigned Q30_TWO_PI = 64'd6746518852;
    localparam int TAYLOR_TERMS = 12;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_BIN  = 1'b1
    } dft_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } dft_state_t;

    typedef struct packed {
        dft_cmd_t                    command;
        logic [9:0]                  sample_index;
        logic signed [SAMPLE_W-1:0]  sample_value;
        logic [9:0]                  bin_index;
    } dft_in_t;

    typedef struct packed {
        logic [9:0]         bin_number;
        logic signed [15:0] bin_real;
        logic signed [15:0] bin_imag;
    } dft_out_t;

    typedef struct packed {
        logic signed [TW_W-1:0] cos_v;
        logic signed [TW_W-1:0] sin_v;
    } dft_tw_t;

    typedef struct packed {
        logic clear;
        logic en;
    } dft_mac_ctrl_t;

    typedef logic [2*TW_W-1:0] tw_rom_t [TW_QUARTER];

    // Round a Q30 value to Q15, clamped to 0..32767.
    function automatic logic [TW_W-1:0] tw_to_q15(input longint v);
        longint unsigned q;
        if (v < 0) begin
            q = 64'd0;
        end else begin
            q = (longint'(unsigned'(v)) + 64'd16384) >> 15;
        end
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[TW_W-1:0];
    endfunction

    // Unsigned quotient by restoring shift and subtract, one bit per step.
    function automatic longint unsigned tw_udiv(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // First-quadrant cos/sin by Taylor series in Q30, one entry per step.
    function automatic tw_rom_t tw_build();
        tw_rom_t         rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint          ss;
        longint          cs;
        for (int r = 0; r < TW_QUARTER; r++) begin
            x  = (Q30_TWO_PI * longint'(r)) >> ADDR_W;
            x2 = (x * x) >> 30;
            ts = x;
            tc = 64'd1 << 30;
            ss = longint'(x);
            cs = longint'(64'd1 << 30);
            for (int i = 1; i <= TAYLOR_TERMS; i++) begin
                ts = tw_udiv((ts * x2) >> 30, 64'((2 * i) * (2 * i + 1)));
                tc = tw_udiv((tc * x2) >> 30, 64'((2 * i - 1) * (2 * i)));
                if (i % 2 == 1) begin
                    ss = ss - longint'(ts);
                    cs = cs - longint'(tc);
                end else begin
                    ss = ss + longint'(ts);
                    cs = cs + longint'(tc);
                end
            end
            rom[r] = {tw_to_q15(cs), tw_to_q15(ss)};
        end
        return rom;
    endfunction

    localparam tw_rom_t TW_ROM = tw_build();

    // Full-circle twiddle from the quarter table by quadrant symmetry.
    function automatic dft_tw_t tw_lookup(input logic [ADDR_W-1:0] a);
        logic [1:0]             q;
        logic [QR_W-1:0]        r;
        logic signed [TW_W-1:0] c;
        logic signed [TW_W-1:0] s;
        dft_tw_t                t;
        q = a[ADDR_W-1:ADDR_W-2];
        r = a[QR_W-1:0];
        c = TW_ROM[r][2*TW_W-1:TW_W];
        s = TW_ROM[r][TW_W-1:0];
        unique case (q)
            2'd0: begin t.cos_v = c;  t.sin_v = s;  end
            2'd1: begin t.cos_v = -s; t.sin_v = c;  end
            2'd2: begin t.cos_v = -c; t.sin_v = -s; end
            2'd3: begin t.cos_v = s;  t.sin_v = -c; end
            default: begin t.cos_v = c; t.sin_v = s; end
        endcase
        return t;
    endfunction

    // Floor shift by log2(N)+15, then saturate to 16 bits.
    function automatic logic signed [15:0] dft_scale(input logic signed [ACC_W-1:0] acc);
        logic [SCALED_W-1:0] sh;
        logic signed [15:0]  res;
        sh = acc[ACC_W-1:OUT_SHIFT];
        if (sh[SCALED_W-1:15] != {(SCALED_W-15){sh[SCALED_W-1]}}) begin
            res = sh[SCALED_W-1] ? 16'sh8000 : 16'sh7fff;
        end else begin
            res = sh[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/dft_bin_engine.sv
// ============================================================================
// dft_bin_engine
// Direct 1024-point DFT, one normalized frequency bin per request.
// ============================================================================
// A load word writes one Q1.15 sample into the sample RAM. A bin word starts
// a sweep that reads one stored sample per cycle from the single RAM read port
// and feeds one cos/sin multiply pair; no new word, load or bin, is taken
// until the result word of that bin has been written to the output register.
// The input side keeps accepting while a finished result waits at the output.
// Every sample that a bin sweeps must have been loaded first.
`default_nettype none

module dft_bin_engine (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire dft_pkg::dft_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output dft_pkg::dft_out_t     m_data
);
    import dft_pkg::*;

    dft_state_t              state_reg;
    dft_state_t              state_next;
    logic [ADDR_W-1:0]       n_reg;
    logic [ADDR_W-1:0]       a_reg;
    logic [9:0]              k_reg;
    logic                    rd_valid_reg;
    dft_tw_t                 tw_reg;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    dft_out_t                m_data_reg;

    logic                    s_accept;
    logic                    load_we;
    logic                    bin_start;
    logic                    ram_re;
    logic                    last_issue;
    logic                    drain_done;
    logic                    out_write;
    logic [SAMPLE_W-1:0]     ram_rdata;
    dft_mac_ctrl_t           mac_ctrl;
    logic                    mac_busy;
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;

    assign s_accept   = s_valid && s_ready;
    assign load_we    = s_accept && (s_data.command == CMD_LOAD);
    assign bin_start  = s_accept && (s_data.command == CMD_BIN);
    assign last_issue = (n_reg == ADDR_W'(DFT_POINTS - 1));
    assign drain_done = !rd_valid_reg && !mac_busy;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (bin_start) state_next = ST_RUN;
            ST_RUN:   if (last_issue) state_next = ST_DRAIN;
            ST_DRAIN: if (out_write) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        ram_re        = (state_reg == ST_RUN);
        mac_ctrl.en    = rd_valid_reg;
        mac_ctrl.clear = bin_start;
        out_write     = (state_reg == ST_DRAIN) && drain_done && (!m_valid_reg || m_ready);
    end

    always_comb begin
        if (out_write) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= ram_re;
            m_valid_reg  <= m_valid_next;
        end
    end

    // sample counter and twiddle address (k*n mod N by repeated add)
    always_ff @(posedge aclk) begin
        if (bin_start) begin
            n_reg <= '0;
            a_reg <= '0;
            k_reg <= s_data.bin_index;
        end else if (ram_re) begin
            n_reg <= n_reg + 1'b1;
            a_reg <= a_reg + k_reg[ADDR_W-1:0];
        end
        // align twiddle with the registered RAM read
        if (ram_re) begin
            tw_reg <= tw_lookup(a_reg);
        end
        if (out_write) begin
            m_data_reg.bin_number <= k_reg;
            m_data_reg.bin_real   <= dft_scale(acc_re);
            m_data_reg.bin_imag   <= dft_scale(acc_im);
        end
    end

    dft_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DFT_POINTS)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (s_data.sample_index[ADDR_W-1:0]),
        .wdata (s_data.sample_value),
        .re    (ram_re),
        .raddr (n_reg),
        .rdata (ram_rdata)
    );

    dft_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .sample  (signed'(ram_rdata)),
        .tw      (tw_reg),
        .busy    (mac_busy),
        .acc_re  (acc_re),
        .acc_im  (acc_im)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_start_run: assert property (@(posedge aclk) disable iff (!aresetn)
        bin_start |=> (state_reg == ST_RUN) && (n_reg == '0) && (a_reg == '0))
        else $error("bin request did not start a fresh sweep");

    a_last_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && last_issue |=> (state_reg == ST_DRAIN))
        else $error("sweep did not end after the last sample");

    a_addr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && !last_issue
        |=> a_reg == ADDR_W'($past(a_reg) + $past(k_reg[ADDR_W-1:0])))
        else $error("twiddle address did not advance by k");

    a_out_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        out_write |-> !rd_valid_reg && !mac_busy && (state_reg == ST_DRAIN))
        else $error("result written before the accumulators settled");

endmodule

`default_nettype wire

### sv/dft_ram.sv
// ============================================================================
// dft_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module dft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/dft_mac.sv
// ============================================================================
// dft_mac
// Shared complex MAC unit: one sample times cos and sin per enabled cycle,
// products registered, then summed into the two 42-bit accumulators.
// ============================================================================
`default_nettype none

module dft_mac (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire dft_pkg::dft_mac_ctrl_t            ctrl,
    input  wire logic signed [dft_pkg::SAMPLE_W-1:0] sample,
    input  wire dft_pkg::dft_tw_t                  tw,
    output logic                                   busy,
    output logic signed [dft_pkg::ACC_W-1:0]       acc_re,
    output logic signed [dft_pkg::ACC_W-1:0]       acc_im
);
    import dft_pkg::*;

    logic signed [PROD_W-1:0] prod_re_reg;
    logic signed [PROD_W-1:0] prod_im_reg;
    logic                     pv_reg;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;
    logic signed [ACC_W-1:0]  acc_re_next;
    logic signed [ACC_W-1:0]  acc_im_next;

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            prod_re_reg <= sample * tw.cos_v;
            prod_im_reg <= sample * tw.sin_v;
        end
    end

    // imaginary part carries the minus sign of the forward kernel
    always_comb begin
        acc_re_next = acc_re_reg + {{(ACC_W-PROD_W){prod_re_reg[PROD_W-1]}}, prod_re_reg};
        acc_im_next = acc_im_reg - {{(ACC_W-PROD_W){prod_im_reg[PROD_W-1]}}, prod_im_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg     <= 1'b0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else begin
            pv_reg <= ctrl.en;
            if (ctrl.clear) begin
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end else if (pv_reg) begin
                acc_re_reg <= acc_re_next;
                acc_im_reg <= acc_im_next;
            end
        end
    end

    assign busy   = pv_reg;
    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

`default_nettype wire
